@@ hdl/rstr_pkg.sv @@
// Package holding the shared types, codes and helper function of the string-to-ratio parser.
package rstr_pkg;

  localparam int VW = 64;
  localparam int PEND_W = 7;
  localparam logic [PEND_W-1:0] PEND_MAX = 7'd127;
  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [7:0] CODE_MINUS = 8'h2d;
  localparam logic [7:0] CODE_POINT = 8'h2e;
  localparam logic [VW-1:0] DEN_LIM = {1'b0, {(VW-1){1'b1}}};

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_OVERFLOW  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CL_MINUS = 2'd0,
    CL_POINT = 2'd1,
    CL_DIGIT = 2'd2,
    CL_BAD   = 2'd3
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [4:0] digit;
    logic [4:0] radix;
    logic       last;
  } tok_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ZERO,
    BK_GCD,
    BK_DIV,
    BK_OUT
  } bk_state_t;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    return v;
  endfunction

endpackage

@@ hdl/radix_string_to_ratio_top.sv @@
// Top level of the radix string to ratio parser.
// Characters enter one word a cycle, while the queue is not full, into a four-word queue;
// the back unit reads each character and, for an integer digit or a nonzero fraction digit,
// makes a multiply step per deferred fraction zero and then one for the digit itself.
// On the last character of a well-formed string without overflow, the reduction runs Euclid
// with a bit-serial remainder until the remainder is zero, then the two divisions in parallel.
// The result is held until out_ready is taken.
module radix_string_to_ratio_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_code,
  input  logic               in_last_char,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_numerator,
  output logic [62:0]        out_denominator,
  output logic [1:0]         out_error_code
);
  import rstr_pkg::*;

  tok_t wr_tok, rd_tok;
  logic q_wr, q_full, q_rd, q_empty;

  rstr_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_data, .in_valid, .in_ready, .in_char_code,
    .in_last_char, .q_full, .q_wr, .q_data(wr_tok)
  );

  rstr_fifo u_fifo (
    .clk, .rst_n, .wr_en(q_wr), .wr_data(wr_tok), .full(q_full), .rd_en(q_rd),
    .rd_data(rd_tok), .empty(q_empty)
  );

  rstr_back u_back (
    .clk, .rst_n, .q_empty, .q_data(rd_tok), .q_rd, .out_valid, .out_ready,
    .out_numerator, .out_denominator, .out_error_code
  );

endmodule

@@ hdl/rstr_fifo.sv @@
// Short queue of classified characters between the front classifier and the back unit.
module rstr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  rstr_pkg::tok_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output rstr_pkg::tok_t rd_data,
  output logic           empty
);
  import rstr_pkg::*;

  tok_t       mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

endmodule

@@ hdl/rstr_front.sv @@
// Front classifier: holds the radix register and tags each character for the back unit.
module rstr_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [4:0]     cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_char_code,
  input  logic           in_last_char,
  input  logic           q_full,
  output logic           q_wr,
  output rstr_pkg::tok_t q_data
);
  import rstr_pkg::*;

  logic [4:0] radix_r;
  logic [4:0] d;

  always_ff @(posedge clk) begin
    if (!rst_n) radix_r <= RADIX_RESET;
    else if (cfg_we) radix_r <= cfg_data;
  end

  assign in_ready = !q_full;
  assign q_wr     = in_valid && !q_full;
  assign d        = digit_value(in_char_code);

  always_comb begin
    q_data.digit = d;
    q_data.radix = radix_r;
    q_data.last  = in_last_char;
    if (radix_r < 5'd2 || radix_r > 5'd16) q_data.cls = CL_BAD;
    else if (in_char_code == CODE_MINUS) q_data.cls = CL_MINUS;
    else if (in_char_code == CODE_POINT) q_data.cls = CL_POINT;
    else if (d < radix_r) q_data.cls = CL_DIGIT;
    else q_data.cls = CL_BAD;
  end

endmodule

@@ hdl/rstr_back.sv @@
// Back unit: accumulates the fraction, applies deferred zeros and reduces by the common divisor.
module rstr_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  rstr_pkg::tok_t         q_data,
  output logic                   q_rd,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [63:0]     out_numerator,
  output logic [62:0]            out_denominator,
  output logic [1:0]             out_error_code
);
  import rstr_pkg::*;

  bk_state_t  st_r, st_nxt;
  logic [VW-1:0] num_r, num_nxt, den_r, den_nxt;
  logic neg_r, neg_nxt, pt_r, pt_nxt, sid_r, sid_nxt, sfd_r, sfd_nxt;
  logic at_r, at_nxt, mal_r, mal_nxt, ovf_r, ovf_nxt;
  logic [PEND_W-1:0] pz_r, pz_nxt;
  tok_t tk_r, tk_nxt;
  // Common divisor and long division working registers.
  logic [VW-1:0] ga_r, ga_nxt, gb_r, gb_nxt, rem_r, rem_nxt;
  logic [VW-1:0] qn_r, qn_nxt, qd_r, qd_nxt, rn_r, rn_nxt, rd_r, rd_nxt;
  logic [6:0]    bit_r, bit_nxt;
  logic signed [63:0] on_r, on_nxt;
  logic [62:0]   od_r, od_nxt;
  err_t          oe_r, oe_nxt;

  logic [VW-1:0] lim, prod_n, prod_d;
  logic [VW+4:0] wide_n, wide_d;
  logic [VW:0]   trial_g, trial_n, trial_d;
  logic [VW-1:0] sh_g, sh_n, sh_d;

  assign lim    = DEN_LIM + VW'(neg_r);
  assign wide_n = num_r * tk_r.radix + (VW+5)'(pz_r == '0 ? tk_r.digit : 5'd0);
  assign wide_d = den_r * tk_r.radix;
  assign prod_n = wide_n[VW-1:0];
  assign prod_d = wide_d[VW-1:0];

  assign sh_g    = {rem_r[VW-2:0], ga_r[VW-1]};
  assign trial_g = {1'b0, sh_g} - {1'b0, gb_r};
  assign sh_n    = {rn_r[VW-2:0], qn_r[VW-1]};
  assign trial_n = {1'b0, sh_n} - {1'b0, ga_r};
  assign sh_d    = {rd_r[VW-2:0], qd_r[VW-1]};
  assign trial_d = {1'b0, sh_d} - {1'b0, ga_r};

  assign out_valid       = (st_r == BK_OUT);
  assign out_numerator   = on_r;
  assign out_denominator = od_r;
  assign out_error_code  = oe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; num_r <= '0; den_r <= VW'(1); neg_r <= 1'b0; pt_r <= 1'b0;
      sid_r <= 1'b0; sfd_r <= 1'b0; at_r <= 1'b1; mal_r <= 1'b0; ovf_r <= 1'b0;
      pz_r <= '0;
    end else begin
      st_r <= st_nxt; num_r <= num_nxt; den_r <= den_nxt; neg_r <= neg_nxt;
      pt_r <= pt_nxt; sid_r <= sid_nxt; sfd_r <= sfd_nxt; at_r <= at_nxt;
      mal_r <= mal_nxt; ovf_r <= ovf_nxt; pz_r <= pz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tk_r <= tk_nxt; ga_r <= ga_nxt; gb_r <= gb_nxt; rem_r <= rem_nxt;
    qn_r <= qn_nxt; qd_r <= qd_nxt; rn_r <= rn_nxt; rd_r <= rd_nxt;
    bit_r <= bit_nxt;
    on_r <= on_nxt; od_r <= od_nxt; oe_r <= oe_nxt;
  end

  always_comb begin
    logic fin;
    st_nxt = st_r; num_nxt = num_r; den_nxt = den_r; neg_nxt = neg_r; pt_nxt = pt_r;
    sid_nxt = sid_r; sfd_nxt = sfd_r; at_nxt = at_r; mal_nxt = mal_r; ovf_nxt = ovf_r;
    pz_nxt = pz_r; tk_nxt = tk_r; ga_nxt = ga_r; gb_nxt = gb_r; rem_nxt = rem_r;
    qn_nxt = qn_r; qd_nxt = qd_r; rn_nxt = rn_r; rd_nxt = rd_r; bit_nxt = bit_r;
    on_nxt = on_r; od_nxt = od_r; oe_nxt = oe_r;
    q_rd = 1'b0;
    fin = 1'b0;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_rd = 1'b1;
          tk_nxt = q_data;
          unique case (q_data.cls)
            CL_BAD: mal_nxt = 1'b1;
            CL_MINUS: begin
              if (at_r) neg_nxt = 1'b1;
              else mal_nxt = 1'b1;
            end
            CL_POINT: begin
              if (pt_r || !sid_r) mal_nxt = 1'b1;
              else pt_nxt = 1'b1;
            end
            CL_DIGIT: begin
              if (!pt_r) sid_nxt = 1'b1;
              else sfd_nxt = 1'b1;
            end
          endcase
          at_nxt = 1'b0;
          if (q_data.cls == CL_DIGIT && (!pt_r || q_data.digit != 5'd0)) begin
            st_nxt = BK_ZERO;
          end else if (q_data.cls == CL_DIGIT) begin
            if (pz_r < PEND_MAX) pz_nxt = pz_r + PEND_W'(1);
            fin = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end
      end
      BK_ZERO: begin
        // One multiply step per cycle: deferred zeros first, then the digit itself.
        if (!ovf_r) begin
          if (wide_n[VW+4:VW] != '0 || prod_n > lim) ovf_nxt = 1'b1;
          else if (pt_r && (wide_d[VW+4:VW] != '0 || prod_d > DEN_LIM)) ovf_nxt = 1'b1;
          else begin
            num_nxt = prod_n;
            if (pt_r) den_nxt = prod_d;
          end
        end
        if (pz_r == '0 || ovf_r) begin
          pz_nxt = '0;
          fin = 1'b1;
        end else begin
          pz_nxt = pz_r - PEND_W'(1);
        end
      end
      BK_GCD: begin
        // Euclid with a bit-serial remainder: a run of VW steps per modulo.
        if (bit_r == 7'd0) begin
          if (gb_r == '0) begin
            st_nxt = BK_DIV;
            qn_nxt = num_r; qd_nxt = den_r; rn_nxt = '0; rd_nxt = '0;
            bit_nxt = 7'(VW);
          end else begin
            rem_nxt = '0; bit_nxt = 7'(VW);
          end
        end else begin
          ga_nxt = {ga_r[VW-2:0], 1'b0};
          if (!trial_g[VW]) rem_nxt = trial_g[VW-1:0];
          else rem_nxt = sh_g;
          bit_nxt = bit_r - 7'd1;
          if (bit_r == 7'd1) begin
            ga_nxt = gb_r;
            gb_nxt = (!trial_g[VW]) ? trial_g[VW-1:0] : sh_g;
            bit_nxt = 7'd0;
          end
        end
      end
      BK_DIV: begin
        if (bit_r == 7'd0) begin
          on_nxt = neg_r ? -$signed(qn_r) : $signed(qn_r);
          od_nxt = qd_r[62:0];
          oe_nxt = ERR_OK;
          st_nxt = BK_OUT;
        end else begin
          qn_nxt = {qn_r[VW-2:0], !trial_n[VW]};
          rn_nxt = trial_n[VW] ? sh_n : trial_n[VW-1:0];
          qd_nxt = {qd_r[VW-2:0], !trial_d[VW]};
          rd_nxt = trial_d[VW] ? sh_d : trial_d[VW-1:0];
          bit_nxt = bit_r - 7'd1;
        end
      end
      BK_OUT: begin
        if (out_ready) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase

    if (fin) begin
      st_nxt = BK_IDLE;
      if (tk_nxt.last) begin
        if (mal_nxt || !sid_nxt || (pt_nxt && !sfd_nxt)) begin
          on_nxt = '0; od_nxt = 63'd1; oe_nxt = ERR_MALFORMED; st_nxt = BK_OUT;
        end else if (ovf_nxt) begin
          on_nxt = '0; od_nxt = 63'd1; oe_nxt = ERR_OVERFLOW; st_nxt = BK_OUT;
        end else begin
          ga_nxt = num_nxt; gb_nxt = den_nxt; bit_nxt = 7'd0; st_nxt = BK_GCD;
        end
        num_nxt = '0; den_nxt = VW'(1); neg_nxt = 1'b0; pt_nxt = 1'b0;
        sid_nxt = 1'b0; sfd_nxt = 1'b0; pz_nxt = '0; at_nxt = 1'b1;
        mal_nxt = 1'b0; ovf_nxt = 1'b0;
        if (st_nxt == BK_GCD) begin
          num_nxt = num_r; den_nxt = den_r; neg_nxt = neg_r;
          if (st_r == BK_ZERO && !ovf_r) begin
            num_nxt = ga_nxt; den_nxt = gb_nxt;
          end
        end
      end
    end

    if (st_r == BK_DIV && bit_r == 7'd0) begin
      num_nxt = '0; den_nxt = VW'(1); neg_nxt = 1'b0;
    end
  end

endmodule

@@ test/tb_radix_string_to_ratio_top.sv @@
// Self-checking testbench of the radix string to ratio parser, with a scoreboard class.
`timescale 1ns / 1ps

module tb_radix_string_to_ratio_top;
  import rstr_pkg::*;

  typedef logic [7:0] char_q_t[$];

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    err_t        err;
  } ratio_t;

  class ratio_scoreboard;
    logic [4:0]  radix;
    logic [63:0] num_acc;
    logic [63:0] den_acc;
    bit          neg, point, int_dig, frac_dig, at_start, bad, ovf;
    int          zeros;
    int          errors;
    ratio_t      ratio_q[$];

    function new();
      radix = RADIX_RESET;
      errors = 0;
      clear();
    endfunction

    function void clear();
      num_acc = 0;
      den_acc = 1;
      neg = 0;
      point = 0;
      int_dig = 0;
      frac_dig = 0;
      at_start = 1;
      bad = 0;
      ovf = 0;
      zeros = 0;
    endfunction

    function logic [4:0] digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      return 5'd16;
    endfunction

    function void num_mac(logic [63:0] d);
      logic [63:0] lim;
      lim = DEN_LIM + (neg ? 64'd1 : 64'd0);
      if (ovf) return;
      if (d > lim || num_acc > (lim - d) / radix) ovf = 1;
      else num_acc = num_acc * radix + d;
    endfunction

    function void den_mul();
      if (ovf) return;
      if (den_acc > DEN_LIM / radix) ovf = 1;
      else den_acc = den_acc * radix;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      logic [4:0]  d;
      logic [63:0] a, b, t;
      ratio_t      r;
      d = digit_of(c);
      if (radix < 2 || radix > 16) begin
        bad = 1;
      end else if (c == CODE_MINUS) begin
        if (at_start) neg = 1;
        else bad = 1;
      end else if (c == CODE_POINT) begin
        if (point || !int_dig) bad = 1;
        else point = 1;
      end else if (d < radix) begin
        if (!point) begin
          int_dig = 1;
          num_mac(d);
        end else begin
          frac_dig = 1;
          if (d == 0) begin
            if (zeros < PEND_MAX) zeros++;
          end else begin
            for (int k = 0; k < zeros && !ovf; k++) begin
              num_mac(0);
              den_mul();
            end
            zeros = 0;
            num_mac(d);
            den_mul();
          end
        end
      end else begin
        bad = 1;
      end
      at_start = 0;
      if (!last) return;
      r.num = 0;
      r.den = 1;
      if (bad || !int_dig || (point && !frac_dig)) begin
        r.err = ERR_MALFORMED;
      end else if (ovf) begin
        r.err = ERR_OVERFLOW;
      end else begin
        a = num_acc;
        b = den_acc;
        while (b != 0) begin
          t = a % b;
          a = b;
          b = t;
        end
        r.num = neg ? -(num_acc / a) : num_acc / a;
        r.den = 63'(den_acc / a);
        r.err = ERR_OK;
      end
      ratio_q.push_back(r);
      clear();
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_ratio(logic [63:0] num, logic [62:0] den, logic [1:0] err);
      ratio_t r;
      if (ratio_q.size() == 0) begin
        report($sformatf("unexpected word num=%0d den=%0d err=%0d", $signed(num), den, err));
        return;
      end
      r = ratio_q.pop_front();
      if (num !== r.num)
        report($sformatf("numerator %0d, wanted %0d", $signed(num), $signed(r.num)));
      if (den !== r.den) report($sformatf("denominator %0d, wanted %0d", den, r.den));
      if (err !== r.err) report($sformatf("error code %0d, wanted %0d", err, r.err));
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [4:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_char_code;
  logic               in_last_char;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_numerator;
  logic [62:0]        out_denominator;
  logic [1:0]         out_error_code;

  ratio_scoreboard sb;
  bit              idle_en;
  bit              hold_req;
  int              items;
  int              cycles;

  radix_string_to_ratio_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_char_code(in_char_code),
    .in_last_char(in_last_char), .out_valid(out_valid), .out_ready(out_ready),
    .out_numerator(out_numerator), .out_denominator(out_denominator),
    .out_error_code(out_error_code)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 40000000) begin
      $display("tb_radix_string_to_ratio_top: done, errors");
      $finish;
    end
  end

  initial begin
    int  hold_cnt;
    int  stall_cnt;
    bit  rdy;
    hold_cnt = 0;
    stall_cnt = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_ratio(out_numerator, out_denominator, out_error_code);
      rdy = 1;
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
        rdy = 0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        rdy = 0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_cnt = $urandom_range(0, 4);
        rdy = 0;
      end
      out_ready <= rdy;
    end
  end

  task automatic send_char(logic [7:0] c, logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    in_char_code <= c;
    in_last_char <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_char(c, last);
    items++;
  endtask

  task automatic send_str(char_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(string t);
    char_q_t s;
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    send_str(s);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.ratio_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_radix(logic [4:0] r);
    cfg_we <= 1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 0;
    sb.radix = r;
  endtask

  function automatic logic [7:0] digit_char(int d);
    if (d < 10) return 8'("0" + d);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(d - 10);
  endfunction

  function automatic char_q_t make_string(logic [4:0] radix);
    char_q_t s;
    int      kind;
    int      top;
    int      n;
    top = (radix >= 2 && radix <= 16) ? radix - 1 : 15;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
      return s;
    end
    if (kind == 1 && radix == 16) begin
      if ($urandom_range(0, 1)) begin
        s.push_back(CODE_MINUS);
        s.push_back(8'("8"));
      end else begin
        s.push_back(8'("7"));
      end
      repeat (15) s.push_back(s[0] == CODE_MINUS ? 8'("0") : 8'("f"));
      return s;
    end
    if ($urandom_range(0, 2) == 0) s.push_back(CODE_MINUS);
    n = (kind == 2) ? $urandom_range(10, 66) : $urandom_range(1, 5);
    repeat (n) s.push_back(digit_char($urandom_range(0, top)));
    if ($urandom_range(0, 1)) begin
      s.push_back(CODE_POINT);
      if (kind == 3) repeat ($urandom_range(20, 130)) s.push_back("0");
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(digit_char($urandom_range(0, top)));
    end
    if (kind >= 17) s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
    if (kind == 16) s.push_back($urandom_range(0, 1) ? CODE_POINT : CODE_MINUS);
    return s;
  endfunction

  initial begin
    logic [4:0] r;
    int         phase;
    int         stop;
    sb = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_data = 0;
    in_valid = 0;
    in_char_code = 0;
    in_last_char = 0;
    out_ready = 0;
    idle_en = 1;
    hold_req = 0;
    items = 0;
    cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_text("-0.0");
    send_text("1.50");
    send_text("--1");
    send_text(".5");
    send_text("1.");
    send_text("1..2");
    send_text("9");
    send_text("a");
    send_char(8'hff, 1);
    drain();

    phase = 0;
    while (items < 1250) begin
      if (phase == 0) r = 5'd2;
      else if (phase == 1) r = 5'd16;
      else if (phase == 2) r = 5'd10;
      else if ($urandom_range(0, 7) == 0) r = 5'($urandom_range(0, 1) ? 17 : $urandom_range(0, 1));
      else r = 5'($urandom_range(2, 16));
      if (phase == 4) r = 5'd31;
      write_radix(r);
      if (phase == 3) hold_req = 1;
      stop = items + 110;
      while (items < stop && items < 1250) begin
        if (items > 1100) idle_en = 0;
        send_str(make_string(r));
      end
      drain();
      phase++;
    end

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.ratio_q.size() == 0)
      $display("tb_radix_string_to_ratio_top: done, clean");
    else
      $display("tb_radix_string_to_ratio_top: done, errors");
    $finish;
  end

endmodule
